// ----- rtl/gcp_pkg.sv -----
// Shared types and constants for the glyph cluster placement block.
// Used by gcp_csr, gcp_divider and glyph_cluster_placement; depends on nothing.
package gcp_pkg;

   localparam int SCRATCH_BYTES = 512;
   localparam int MAX_GLYPHS    = 8;

   localparam int DIVIDEND_W = 24;
   localparam int DIVISOR_W  = 16;
   localparam int DIV_STEPS  = DIVIDEND_W;
   localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
   localparam int SEEN_W     = 4;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PIXEL_SIZE     = 3'd0,
      CSR_UNITS_PER_EM   = 3'd1,
      CSR_BASELINE_ROW   = 3'd2,
      CSR_BITS_PER_PIXEL = 3'd3,
      CSR_GLYPH_LIMIT    = 3'd4,
      CSR_DRAW_ENABLE    = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [7:0]  pixel_size;
      logic [15:0] units_per_em;
      logic [7:0]  baseline_row;
      logic [3:0]  bits_per_pixel;
      logic [15:0] glyph_limit;
      logic        draw_enable;
   } cfg_type;

   typedef struct packed {
      logic                  start;
      logic [DIVIDEND_W-1:0] dividend;
      logic [DIVISOR_W-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic                  busy;
      logic                  done;
      logic [DIVIDEND_W-1:0] quotient;
   } div_rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SIZE,
      ST_CHECK,
      ST_MUL,
      ST_WAIT,
      ST_SUM
   } state_type;

   typedef enum logic [1:0] {
      OP_ADV,
      OP_X,
      OP_Y
   } op_type;

endpackage

// ----- rtl/gcp_csr.sv -----
// Configuration register file of the glyph cluster placement block.
// Depends on gcp_pkg for the register indexes and the configuration struct.
module gcp_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [gcp_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [gcp_pkg::CSR_DATA_W-1:0]   csr_data,
   output gcp_pkg::cfg_type                 cfg
);

   gcp_pkg::cfg_type cfg_ff;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pixel_size     <= 8'd16;
         cfg_ff.units_per_em   <= 16'd1000;
         cfg_ff.baseline_row   <= 8'd0;
         cfg_ff.bits_per_pixel <= 4'd2;
         cfg_ff.glyph_limit    <= 16'd0;
         cfg_ff.draw_enable    <= 1'b1;
      end else if (csr_valid && csr_ready) begin
         case (gcp_pkg::csr_index_type'(csr_index))
            gcp_pkg::CSR_PIXEL_SIZE:     cfg_ff.pixel_size     <= csr_data[7:0];
            gcp_pkg::CSR_UNITS_PER_EM:   cfg_ff.units_per_em   <= csr_data;
            gcp_pkg::CSR_BASELINE_ROW:   cfg_ff.baseline_row   <= csr_data[7:0];
            gcp_pkg::CSR_BITS_PER_PIXEL: cfg_ff.bits_per_pixel <= csr_data[3:0];
            gcp_pkg::CSR_GLYPH_LIMIT:    cfg_ff.glyph_limit    <= csr_data;
            gcp_pkg::CSR_DRAW_ENABLE:    cfg_ff.draw_enable    <= csr_data[0];
            default: ;
         endcase
      end
   end

endmodule

// ----- rtl/gcp_divider.sv -----
// Radix-2 restoring divider, one quotient bit per cycle, shared by all scalings.
// Depends on gcp_pkg for widths and the request and response structs.
module gcp_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  gcp_pkg::div_req_type req,
   output gcp_pkg::div_rsp_type rsp
);

   logic                             busy_ff, done_ff;
   logic [gcp_pkg::DIV_CNT_W-1:0]    count_ff;
   logic [gcp_pkg::DIVIDEND_W-1:0]   quo_ff, quo_in;
   logic [gcp_pkg::DIVISOR_W-1:0]    rem_ff, rem_in, div_ff;
   logic [gcp_pkg::DIVISOR_W:0]      rem_shift, rem_diff;
   logic                             ge;

   // The quotient register starts as the dividend; its top bit is shifted into
   // the partial remainder while each new quotient bit enters at the bottom.
   always_comb begin
      rem_shift = {rem_ff, quo_ff[gcp_pkg::DIVIDEND_W-1]};
      rem_diff  = rem_shift - {1'b0, div_ff};
      ge        = rem_shift >= {1'b0, div_ff};
      rem_in    = ge ? rem_diff[gcp_pkg::DIVISOR_W-1:0] : rem_shift[gcp_pkg::DIVISOR_W-1:0];
      quo_in    = {quo_ff[gcp_pkg::DIVIDEND_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req.start && !busy_ff) begin
            busy_ff  <= 1'b1;
            count_ff <= gcp_pkg::DIV_CNT_W'(gcp_pkg::DIV_STEPS - 1);
         end else if (busy_ff) begin
            count_ff <= count_ff - 1'b1;
            if (count_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.start && !busy_ff) begin
         quo_ff <= req.dividend;
         rem_ff <= '0;
         div_ff <= req.divisor;
      end else if (busy_ff) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

   assign rsp.busy     = busy_ff;
   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

endmodule

// ----- rtl/glyph_cluster_placement.sv -----
// Top level of the glyph cluster placement block: sequencer, placement datapath
// and output register. Depends on gcp_pkg, gcp_csr and gcp_divider.
//
//   Channel   Direction  Transfer when            Content
//   req_*     in         req_tvalid & req_tready   one glyph of a cluster
//   rsp_*     out        rsp_tvalid & rsp_tready   placement of that glyph
//   csr_*     in         csr_valid & csr_ready     register write, always ready
//
// An item takes one divider pass when it is not drawn and three when it is:
// each scaling by size/upem is one pass of the shared 24-step divider. A glyph
// past the cluster limit, or a zero upem, skips the divider.
// Reset is synchronous and restores the register defaults, pen offset and count.
// A result waits in the output register; the next glyph is accepted meanwhile.
module glyph_cluster_placement (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // Fields from bit 0: origin_x, origin_y, glyph_index, x_offset_du,
   // y_offset_du, advance_du, glyph_width, glyph_height, left_bearing,
   // rows_above_base, fetch_error, zero fill.
   input  logic [135:0]                     req_tdata,
   // Fields from bit 0: first_in_cluster.
   input  logic                             req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // Fields from bit 0: blit_x, blit_y, bitmap_bytes, cluster_advance, zero fill.
   output logic [63:0]                      rsp_tdata,
   // Fields from bit 0: blit_valid.
   output logic                             rsp_tuser,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [gcp_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [gcp_pkg::CSR_DATA_W-1:0]   csr_data
);

   gcp_pkg::cfg_type     cfg;
   gcp_pkg::div_req_type div_req;
   gcp_pkg::div_rsp_type div_rsp;

   gcp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   gcp_divider u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   gcp_pkg::state_type state_ff, state_in;
   gcp_pkg::op_type    op_ff;

   // Captured glyph.
   logic [15:0] ox_ff, oy_ff, idx_ff, xoff_ff, yoff_ff, adv_ff;
   logic [7:0]  w_ff, h_ff, lb_ff, above_ff;
   logic        ferr_ff;

   logic                        skip_ff, valid_ff;
   logic [15:0]                 nbytes_ff;
   logic [gcp_pkg::DIVIDEND_W-1:0] advq_ff;
   logic [15:0]                 sx_ff, sy_ff;
   logic [31:0]                 pen_ff, pen_in;
   logic [gcp_pkg::SEEN_W-1:0]  seen_ff;

   logic        rsp_valid_ff, blit_valid_ff;
   logic [15:0] blit_x_ff, blit_y_ff, adv_out_ff;
   logic [9:0]  bytes_ff;

   // Sequencer outputs.
   logic accept, do_size, do_check, load_out, div_start;

   logic        upem_zero, skip_now, valid_now;
   logic [15:0] mag, qmag, scaled, bx, by;
   logic [7:0]  stride;
   logic        neg;

   function automatic logic [7:0] stride_of(input logic [7:0] w, input logic [3:0] bpp);
      logic [8:0] s;
      begin
         s = 9'd0;
         case (bpp) inside
            4'd1:         s = (9'(w) + 9'd7) >> 3;
            4'd2:         s = (9'(w) + 9'd3) >> 2;
            [4'd3:4'd4]:  s = (9'(w) + 9'd1) >> 1;
            [4'd5:4'd8]:  s = 9'(w);
            default:      s = 9'd0;
         endcase
         return s[7:0];
      end
   endfunction

   assign upem_zero = cfg.units_per_em == 16'd0;
   assign stride    = stride_of(w_ff, cfg.bits_per_pixel);
   assign skip_now  = !req_tuser && (seen_ff >= gcp_pkg::SEEN_W'(gcp_pkg::MAX_GLYPHS));
   assign valid_now = cfg.draw_enable && !ferr_ff && (idx_ff < cfg.glyph_limit) &&
                      (w_ff != 8'd0) && (h_ff != 8'd0) && (nbytes_ff != 16'd0) &&
                      (nbytes_ff <= 16'(gcp_pkg::SCRATCH_BYTES));

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         gcp_pkg::ST_IDLE:  if (req_tvalid) state_in = gcp_pkg::ST_SIZE;
         gcp_pkg::ST_SIZE:  state_in = gcp_pkg::ST_CHECK;
         gcp_pkg::ST_CHECK: state_in = (skip_ff || upem_zero) ? gcp_pkg::ST_SUM
                                                               : gcp_pkg::ST_MUL;
         gcp_pkg::ST_MUL:   state_in = gcp_pkg::ST_WAIT;
         gcp_pkg::ST_WAIT: begin
            if (div_rsp.done) begin
               if ((op_ff == gcp_pkg::OP_ADV && valid_ff) || op_ff == gcp_pkg::OP_X)
                  state_in = gcp_pkg::ST_MUL;
               else
                  state_in = gcp_pkg::ST_SUM;
            end
         end
         gcp_pkg::ST_SUM:   if (!rsp_valid_ff || rsp_tready) state_in = gcp_pkg::ST_IDLE;
         default:           state_in = gcp_pkg::ST_IDLE;
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      req_tready = 1'b0;
      do_size    = 1'b0;
      do_check   = 1'b0;
      load_out   = 1'b0;
      div_start  = 1'b0;
      case (state_ff)
         gcp_pkg::ST_IDLE:  req_tready = 1'b1;
         gcp_pkg::ST_SIZE:  do_size    = 1'b1;
         gcp_pkg::ST_CHECK: do_check   = 1'b1;
         gcp_pkg::ST_MUL:   div_start  = 1'b1;
         gcp_pkg::ST_SUM:   load_out   = !rsp_valid_ff || rsp_tready;
         default: ;
      endcase
   end

   assign accept = req_tvalid && req_tready;

   // Operand for the current scaling; the divider works on magnitudes.
   always_comb begin
      case (op_ff)
         gcp_pkg::OP_X: begin
            neg = xoff_ff[15];
            mag = neg ? (~xoff_ff + 16'd1) : xoff_ff;
         end
         gcp_pkg::OP_Y: begin
            neg = yoff_ff[15];
            mag = neg ? (~yoff_ff + 16'd1) : yoff_ff;
         end
         default: begin
            neg = 1'b0;
            mag = adv_ff;
         end
      endcase
      div_req.start    = div_start;
      div_req.dividend = gcp_pkg::DIVIDEND_W'(mag) * gcp_pkg::DIVIDEND_W'(cfg.pixel_size);
      div_req.divisor  = cfg.units_per_em;
      qmag             = div_rsp.quotient[15:0];
      scaled           = neg ? (~qmag + 16'd1) : qmag;
   end

   assign bx     = ox_ff + pen_ff[15:0] + sx_ff + {{8{lb_ff[7]}}, lb_ff};
   assign by     = oy_ff + {{8{cfg.baseline_row[7]}}, cfg.baseline_row}
                   - {{8{above_ff[7]}}, above_ff} - sy_ff;
   assign pen_in = skip_ff ? pen_ff : pen_ff + {8'd0, advq_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gcp_pkg::ST_IDLE;
         pen_ff       <= '0;
         seen_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (accept && req_tuser) begin
            pen_ff  <= '0;
            seen_ff <= '0;
         end
         if (do_check && !skip_ff)
            seen_ff <= seen_ff + 1'b1;
         if (load_out) begin
            pen_ff       <= pen_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         ox_ff    <= req_tdata[15:0];
         oy_ff    <= req_tdata[31:16];
         idx_ff   <= req_tdata[47:32];
         xoff_ff  <= req_tdata[63:48];
         yoff_ff  <= req_tdata[79:64];
         adv_ff   <= req_tdata[95:80];
         w_ff     <= req_tdata[103:96];
         h_ff     <= req_tdata[111:104];
         lb_ff    <= req_tdata[119:112];
         above_ff <= req_tdata[127:120];
         ferr_ff  <= req_tdata[128];
         skip_ff  <= skip_now;
      end
      if (do_size)
         nbytes_ff <= 16'(stride) * 16'(h_ff);
      if (do_check) begin
         valid_ff <= valid_now && !skip_ff;
         op_ff    <= gcp_pkg::OP_ADV;
         advq_ff  <= '0;
         sx_ff    <= '0;
         sy_ff    <= '0;
      end
      if (state_ff == gcp_pkg::ST_WAIT && div_rsp.done) begin
         case (op_ff)
            gcp_pkg::OP_ADV: begin
               advq_ff <= div_rsp.quotient;
               op_ff   <= gcp_pkg::OP_X;
            end
            gcp_pkg::OP_X: begin
               sx_ff <= scaled;
               op_ff <= gcp_pkg::OP_Y;
            end
            default: sy_ff <= scaled;
         endcase
      end
      if (load_out) begin
         blit_valid_ff <= valid_ff;
         blit_x_ff     <= valid_ff ? bx : 16'd0;
         blit_y_ff     <= valid_ff ? by : 16'd0;
         bytes_ff      <= valid_ff ? nbytes_ff[9:0] : 10'd0;
         adv_out_ff    <= pen_in[15:0];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = blit_valid_ff;
   assign rsp_tdata  = {6'd0, adv_out_ff, bytes_ff, blit_y_ff, blit_x_ff};

   // A drawn glyph always carries a bitmap that fits the scratch buffer.
   a_bytes_fit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> (rsp_tdata[41:32] != 10'd0) &&
                                  (rsp_tdata[41:32] <= 10'(gcp_pkg::SCRATCH_BYTES)))
      else $error("drawn glyph with bitmap size out of range");

   a_not_drawn_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[41:0] == 42'd0)
      else $error("glyph not drawn but placement fields nonzero");

   a_start_idle_div: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !div_rsp.busy)
      else $error("divider started while busy");

   a_seen_bound: assert property (@(posedge clock) disable iff (reset)
      seen_ff <= gcp_pkg::SEEN_W'(gcp_pkg::MAX_GLYPHS))
      else $error("glyph count beyond cluster limit");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second glyph accepted while one is in progress");

endmodule

// ----- dv/tb.sv -----
// Self-checking testbench for glyph_cluster_placement: drives glyph items and
// register writes, predicts every placement and compares it field by field.
// Depends on rtl/gcp_pkg.sv and rtl/glyph_cluster_placement.sv.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int HOLD_CYCLES  = 400;
   localparam int SETTLE       = 8;
   localparam int TAIL_CYCLES  = 100;
   localparam int PHASES       = 10;
   localparam int PHASE_GLYPHS = 120;

   // One glyph item, packed as on req_tdata (origin_x in the lowest bits).
   typedef struct packed {
      logic              fetch_error;
      logic signed [7:0] rows_above_base;
      logic signed [7:0] left_bearing;
      logic [7:0]        glyph_height;
      logic [7:0]        glyph_width;
      logic [15:0]       advance_du;
      logic [15:0]       y_offset_du;
      logic [15:0]       x_offset_du;
      logic [15:0]       glyph_index;
      logic [15:0]       origin_y;
      logic [15:0]       origin_x;
   } glyph_type;

   // One placement: blit_valid travels on tuser, the rest on tdata.
   typedef struct packed {
      logic        blit_valid;
      logic [15:0] cluster_advance;
      logic [9:0]  bitmap_bytes;
      logic [15:0] blit_y;
      logic [15:0] blit_x;
   } placement_type;

   typedef enum {RX_ALWAYS, RX_RANDOM, RX_RUNS} rx_mode_type;

   logic                            clock;
   logic                            reset      = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [135:0]                    req_tdata  = '0;
   logic                            req_tuser  = 1'b0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [63:0]                     rsp_tdata;
   logic                            rsp_tuser;
   logic                            csr_valid  = 1'b0;
   logic                            csr_ready;
   logic [gcp_pkg::CSR_INDEX_W-1:0] csr_index  = '0;
   logic [gcp_pkg::CSR_DATA_W-1:0]  csr_data   = '0;

   // Predictor copy of the registers and of the cluster state.
   logic [7:0]        cfg_size   = 8'd16;
   logic [15:0]       cfg_upem   = 16'd1000;
   logic signed [7:0] cfg_base   = 8'sd0;
   logic [3:0]        cfg_bpp    = 4'd2;
   logic [15:0]       cfg_limit  = 16'd0;
   logic              cfg_draw   = 1'b1;
   logic [31:0]       pen_offset = '0;
   int                glyphs_seen = 0;

   placement_type pending_placements[$];
   placement_type want_place, got_place;

   int mismatches      = 0;
   int results_checked = 0;
   int drawn_results   = 0;
   int glyphs_sent     = 0;
   int clusters_sent   = 0;
   int csr_writes      = 0;

   // Receiver control: mode and hold request come from the test sequence.
   rx_mode_type rx_mode    = RX_ALWAYS;
   int          hold_token = 0;
   int          hold_seen  = 0;
   int          hold_left  = 0;
   int          run_left   = 0;
   bit          run_ready  = 1'b1;

   // Sender pacing.
   bit pace_on    = 1'b1;
   int burst_left = 0;

   glyph_cluster_placement i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #10ms;
      $display("Some tests failed");
      $finish;
   end

   // Design units to pixels, truncated toward zero, kept to 16 bits signed.
   function automatic int scale_du(logic [15:0] du);
      int                prod;
      int                q;
      logic signed [15:0] q16;
      if (cfg_upem == 16'd0) return 0;
      prod = $signed(du);
      prod = prod * int'(cfg_size);
      q    = prod / int'(cfg_upem);
      q16  = q[15:0];
      return q16;
   endfunction

   function automatic placement_type place_glyph(bit first, glyph_type g);
      placement_type r;
      int            w, h, ppb, nbytes, bx, by, base;
      bit            drawn;
      r = '0;
      if (first) begin
         pen_offset  = '0;
         glyphs_seen = 0;
      end
      if (glyphs_seen >= gcp_pkg::MAX_GLYPHS) begin
         r.cluster_advance = pen_offset[15:0];
         return r;
      end
      glyphs_seen++;
      w = g.glyph_width;
      h = g.glyph_height;
      if (cfg_bpp == 4'd0 || cfg_bpp > 4'd8 || w == 0) begin
         nbytes = 0;
      end else begin
         ppb    = 8 / int'(cfg_bpp);
         nbytes = (w + ppb - 1) / ppb * h;
      end
      drawn = cfg_draw && !g.fetch_error && g.glyph_index < cfg_limit && w != 0 &&
              h != 0 && nbytes != 0 && nbytes <= gcp_pkg::SCRATCH_BYTES;
      if (drawn) begin
         base = cfg_base;
         bx = $signed(g.origin_x) + int'(pen_offset) + scale_du(g.x_offset_du) +
              $signed(g.left_bearing);
         by = $signed(g.origin_y) + base - $signed(g.rows_above_base) -
              scale_du(g.y_offset_du);
         r.blit_valid   = 1'b1;
         r.blit_x       = bx[15:0];
         r.blit_y       = by[15:0];
         r.bitmap_bytes = nbytes[9:0];
      end
      // The advance counts whether or not the glyph is drawn.
      if (cfg_upem != 16'd0)
         pen_offset += (32'(g.advance_du) * 32'(cfg_size)) / 32'(cfg_upem);
      r.cluster_advance = pen_offset[15:0];
      return r;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      mismatches++;
      if (mismatches <= 40)
         $display("MISMATCH at result %0d, %s: got %0d, expected %0d",
                  results_checked, what, got, want);
   endtask

   // Result checking and receiver stalls share one process.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_place = {rsp_tuser, rsp_tdata[57:0]};
         if (pending_placements.size() == 0) begin
            report_mismatch("result with none outstanding", 1, 0);
         end else begin
            want_place = pending_placements.pop_front();
            if (got_place.blit_valid != want_place.blit_valid)
               report_mismatch("blit_valid", got_place.blit_valid, want_place.blit_valid);
            if (got_place.blit_x != want_place.blit_x)
               report_mismatch("blit_x", got_place.blit_x, want_place.blit_x);
            if (got_place.blit_y != want_place.blit_y)
               report_mismatch("blit_y", got_place.blit_y, want_place.blit_y);
            if (got_place.bitmap_bytes != want_place.bitmap_bytes)
               report_mismatch("bitmap_bytes", got_place.bitmap_bytes,
                               want_place.bitmap_bytes);
            if (got_place.cluster_advance != want_place.cluster_advance)
               report_mismatch("cluster_advance", got_place.cluster_advance,
                               want_place.cluster_advance);
            if (want_place.blit_valid) drawn_results++;
         end
         results_checked++;
      end

      if (hold_token != hold_seen) begin
         hold_seen = hold_token;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         case (rx_mode)
            RX_ALWAYS: rsp_tready <= 1'b1;
            RX_RANDOM: rsp_tready <= ($urandom_range(0, 3) != 0);
            default: begin
               if (run_left == 0) begin
                  run_ready = !run_ready;
                  run_left  = run_ready ? $urandom_range(1, 12) : $urandom_range(1, 30);
               end else begin
                  run_left--;
               end
               rsp_tready <= run_ready;
            end
         endcase
      end
   end

   // Offers one glyph and returns at the edge where it transfers, valid still high.
   task automatic send_glyph(bit first, glyph_type g);
      req_tvalid <= 1'b1;
      req_tuser  <= first;
      req_tdata  <= {7'b0, g};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_placements.push_back(place_glyph(first, g));
      glyphs_sent++;
      if (first) clusters_sent++;
   endtask

   task automatic pause(int cycles);
      req_tvalid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic send_paced(bit first, glyph_type g);
      send_glyph(first, g);
      if (pace_on) begin
         if (burst_left == 0) begin
            pause($urandom_range(1, 12));
            burst_left = $urandom_range(1, 16);
         end else begin
            burst_left--;
         end
      end
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_placements.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic cfg_write(gcp_pkg::csr_index_type idx, logic [15:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         gcp_pkg::CSR_PIXEL_SIZE:     cfg_size  = data[7:0];
         gcp_pkg::CSR_UNITS_PER_EM:   cfg_upem  = data;
         gcp_pkg::CSR_BASELINE_ROW:   cfg_base  = data[7:0];
         gcp_pkg::CSR_BITS_PER_PIXEL: cfg_bpp   = data[3:0];
         gcp_pkg::CSR_GLYPH_LIMIT:    cfg_limit = data;
         gcp_pkg::CSR_DRAW_ENABLE:    cfg_draw  = data[0];
         default: ;
      endcase
      csr_writes++;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Waits for the block to go idle, then writes every register. Unused upper
   // data bits carry noise, which the registers must drop.
   task automatic apply_settings(logic [7:0] size, logic [15:0] upem, logic [7:0] base,
                                 logic [3:0] bpp, logic [15:0] limit, bit draw);
      drain();
      cfg_write(gcp_pkg::CSR_PIXEL_SIZE, {8'($urandom), size});
      cfg_write(gcp_pkg::CSR_UNITS_PER_EM, upem);
      cfg_write(gcp_pkg::CSR_BASELINE_ROW, {8'($urandom), base});
      cfg_write(gcp_pkg::CSR_BITS_PER_PIXEL, {12'($urandom), bpp});
      cfg_write(gcp_pkg::CSR_GLYPH_LIMIT, limit);
      cfg_write(gcp_pkg::CSR_DRAW_ENABLE, {15'($urandom), draw});
   endtask

   // A plausible glyph that gets drawn under ordinary settings.
   function automatic glyph_type tame_glyph();
      glyph_type g;
      g.origin_x        = 16'($urandom);
      g.origin_y        = 16'($urandom);
      g.glyph_index     = 16'($urandom_range(0, 99));
      g.x_offset_du     = 16'($urandom_range(0, 1000)) - 16'd500;
      g.y_offset_du     = 16'($urandom_range(0, 1000)) - 16'd500;
      g.advance_du      = 16'($urandom_range(0, 2000));
      g.glyph_width     = 8'($urandom_range(1, 16));
      g.glyph_height    = 8'($urandom_range(1, 16));
      g.left_bearing    = 8'($urandom);
      g.rows_above_base = 8'($urandom);
      g.fetch_error     = 1'b0;
      return g;
   endfunction

   function automatic glyph_type random_glyph();
      glyph_type g;
      g = tame_glyph();
      if ($urandom_range(0, 4) == 0)
         g.glyph_index = 16'($urandom);
      else
         g.glyph_index = (cfg_limit == 16'd0) ? 16'd0 :
                         16'($urandom_range(0, int'(cfg_limit) - 1));
      if ($urandom_range(0, 3) == 0) g.x_offset_du = 16'($urandom);
      if ($urandom_range(0, 3) == 0) g.y_offset_du = 16'($urandom);
      g.advance_du = ($urandom_range(0, 5) == 0) ? 16'($urandom) :
                     16'($urandom_range(0, 3000));
      g.glyph_width  = ($urandom_range(0, 5) == 0) ? 8'($urandom) :
                       8'($urandom_range(0, 24));
      g.glyph_height = ($urandom_range(0, 5) == 0) ? 8'($urandom) :
                       8'($urandom_range(0, 24));
      g.fetch_error  = ($urandom_range(0, 19) == 0);
      return g;
   endfunction

   task automatic random_settings();
      logic [7:0]  size;
      logic [15:0] upem;
      logic [3:0]  bpp;
      logic [15:0] limit;
      case ($urandom_range(0, 5))
         0:       size = 8'd0;
         1:       size = 8'd255;
         default: size = 8'($urandom_range(8, 64));
      endcase
      case ($urandom_range(0, 7))
         0:       upem = 16'd0;
         1:       upem = 16'd1;
         2:       upem = 16'hFFFF;
         3:       upem = 16'($urandom_range(1, 65535));
         4:       upem = 16'd2048;
         default: upem = 16'($urandom_range(256, 4096));
      endcase
      bpp = ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'($urandom_range(1, 8));
      case ($urandom_range(0, 7))
         0:       limit = 16'd0;
         1, 2:    limit = 16'hFFFF;
         default: limit = 16'($urandom_range(1, 65535));
      endcase
      apply_settings(size, upem, 8'($urandom), bpp, limit, $urandom_range(0, 7) != 0);
   endtask

   task automatic test_reset_defaults();
      glyph_type g;
      // Glyph limit resets to zero, so nothing is drawn; only the pen moves.
      g = tame_glyph();
      g.advance_du = 16'd1000;
      send_paced(1'b1, g);
      g = tame_glyph();
      g.advance_du = 16'd999;
      send_paced(1'b0, g);
      drain();
   endtask

   task automatic test_field_extremes();
      glyph_type g;
      // A scale of 255 per design unit pushes offsets far past 16 bits.
      apply_settings(8'd255, 16'd1, 8'h7F, 4'd1, 16'hFFFF, 1'b1);
      g = '{fetch_error: 1'b0, rows_above_base: 8'h80, left_bearing: 8'h7F,
            glyph_height: 8'd64, glyph_width: 8'd8, advance_du: 16'hFFFF,
            y_offset_du: 16'h7FFF, x_offset_du: 16'h7FFF, glyph_index: 16'd0,
            origin_y: 16'h7FFF, origin_x: 16'h7FFF};
      send_paced(1'b1, g);
      g = '{fetch_error: 1'b0, rows_above_base: 8'h7F, left_bearing: 8'h80,
            glyph_height: 8'd2, glyph_width: 8'd255, advance_du: 16'd0,
            y_offset_du: 16'h8000, x_offset_du: 16'h8000, glyph_index: 16'hFFFE,
            origin_y: 16'h8000, origin_x: 16'h8000};
      send_paced(1'b0, g);
      g = tame_glyph();
      g.glyph_index = 16'hFFFF;          // equal to the limit, not drawn
      send_paced(1'b0, g);
      g = tame_glyph();
      g.glyph_width  = 8'd255;
      g.glyph_height = 8'd255;           // far over the scratch buffer
      send_paced(1'b0, g);
      g = tame_glyph();
      g.glyph_width = 8'd0;
      send_paced(1'b0, g);
      g = tame_glyph();
      g.glyph_height = 8'd0;
      send_paced(1'b0, g);
      g = tame_glyph();
      g.fetch_error = 1'b1;
      send_paced(1'b0, g);
      // At one bit per pixel, 64 x 64 fills the buffer exactly; one row more overflows it.
      g = tame_glyph();
      g.glyph_width  = 8'd64;
      g.glyph_height = 8'd64;
      send_paced(1'b1, g);
      g.glyph_height = 8'd65;
      send_paced(1'b0, g);
      drain();
   endtask

   task automatic test_cluster_limit();
      rx_mode <= RX_RUNS;
      apply_settings(8'd24, 16'd2048, 8'hEC, 4'd4, 16'd1000, 1'b1);
      // Glyphs past the eighth leave the pen where it is.
      for (int i = 0; i < 10; i++) send_paced(i == 0, tame_glyph());
      send_paced(1'b0, tame_glyph());
      send_paced(1'b1, tame_glyph());
      drain();
   endtask

   task automatic test_scaling_edges();
      glyph_type g;
      rx_mode <= RX_RANDOM;
      apply_settings(8'd200, 16'd0, 8'h80, 4'd2, 16'hFFFF, 1'b1);
      g = tame_glyph();
      g.x_offset_du = 16'h7FFF;
      g.y_offset_du = 16'h8000;
      g.advance_du  = 16'hFFFF;
      send_paced(1'b1, g);
      send_paced(1'b0, tame_glyph());
      apply_settings(8'd0, 16'd1000, 8'h7F, 4'd8, 16'hFFFF, 1'b1);
      send_paced(1'b1, tame_glyph());
      apply_settings(8'd16, 16'd1000, 8'h00, 4'd0, 16'hFFFF, 1'b1);
      send_paced(1'b0, tame_glyph());
      apply_settings(8'd16, 16'd1000, 8'h00, 4'd15, 16'hFFFF, 1'b1);
      send_paced(1'b0, tame_glyph());
      apply_settings(8'd16, 16'd1000, 8'h00, 4'd2, 16'hFFFF, 1'b0);
      send_paced(1'b0, tame_glyph());
      drain();
   endtask

   task automatic test_output_stall();
      apply_settings(8'd16, 16'd1000, 8'd12, 4'd2, 16'hFFFF, 1'b1);
      rx_mode    <= RX_ALWAYS;
      hold_token <= hold_token + 1;
      // With the output held off, the block fills and must push back on its input.
      for (int i = 0; i < 14; i++) send_glyph(i % 5 == 0, tame_glyph());
      drain();
   endtask

   task automatic test_random_clusters();
      int left;
      int len;
      bit broken;
      for (int p = 0; p < PHASES; p++) begin
         random_settings();
         case ($urandom_range(0, 2))
            0:       rx_mode <= RX_ALWAYS;
            1:       rx_mode <= RX_RANDOM;
            default: rx_mode <= RX_RUNS;
         endcase
         pace_on = ($urandom_range(0, 3) != 0);
         left = PHASE_GLYPHS;
         while (left > 0) begin
            len    = $urandom_range(1, 11);
            broken = ($urandom_range(0, 9) == 0);
            for (int i = 0; i < len && left > 0; i++) begin
               send_paced(broken ? 1'($urandom) : (i == 0), random_glyph());
               left--;
            end
         end
      end
      pace_on = 1'b1;
      drain();
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_field_extremes();
      test_cluster_limit();
      test_scaling_edges();
      test_output_stall();
      test_random_clusters();

      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (pending_placements.size() != 0)
         report_mismatch("placements never delivered", 0, pending_placements.size());

      $display("Run covered %0d glyphs in %0d clusters under %0d register writes.",
               glyphs_sent, clusters_sent, csr_writes);
      $display("%0d placements compared, %0d drawn, %0d field mismatches.",
               results_checked, drawn_results, mismatches);
      if (mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/gcp_pkg.sv
rtl/gcp_csr.sv
rtl/gcp_divider.sv
rtl/glyph_cluster_placement.sv
dv/tb.sv
